// ===== sv/quadratic_bisection_root_top_defines.svh =====
// Assertion macros for the quadratic bisection root block.
`ifndef QUADRATIC_BISECTION_ROOT_TOP_DEFINES_SVH
`define QUADRATIC_BISECTION_ROOT_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define QBR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define QBR_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("assertion failed");
`else
`define QBR_ASSERT(lbl, prop)
`define QBR_ASSERT_RST(lbl, prop)
`endif

`endif

// ===== sv/qbr_pkg.sv =====
package qbr_pkg;

  localparam int FRAC_BITS_DEF     = 16;
  localparam int TOLERANCE_LSB_DEF = 6;
  localparam int COEF_BITS_DEF     = 16;

  localparam int DigitBits = 17;
  localparam int ROOT_W    = 33;
  localparam int RES_W     = 48;
  localparam int ST_W      = 2;

  localparam logic [ST_W-1:0] ST_FOUND     = 2'd0;
  localparam logic [ST_W-1:0] ST_QUAD_ZERO = 2'd1;
  localparam logic [ST_W-1:0] ST_NEG_RAD   = 2'd2;
  localparam logic [ST_W-1:0] ST_NO_CHANGE = 2'd3;

  localparam logic [1:0] SEL_X1 = 2'd0;
  localparam logic [1:0] SEL_X2 = 2'd1;
  localparam logic [1:0] SEL_X0 = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_CALC,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_BRACKET,
    OP_EV_START,
    OP_MUL_STEP,
    OP_ADD_LIN,
    OP_ADD_CONST,
    OP_SAVE_S1,
    OP_SAVE_S2,
    OP_MID,
    OP_KEEP_LO,
    OP_KEEP_HI,
    OP_FINISH
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [1:0]      sel;
    logic            first;
    logic [ST_W-1:0] status;
  } cmd_t;

  typedef struct packed {
    logic a_zero;
    logic n_neg;
    logic stop;
    logic f_neg;
    logic f_zero;
    logic s1_neg;
    logic s1_zero;
    logic s2_neg;
    logic s2_zero;
  } sts_t;

endpackage

// ===== sv/quadratic_bisection_root_top.sv =====
// Quadratic root finder by bisection.
// Drive coef_quad_i, coef_lin_i and coef_const_i and pulse start_i while
// busy_o is low; the coefficients are taken at that clock edge.
// The block first forms the bracket radius with a restoring divider, one
// quotient bit per cycle, and a digit-by-digit square root, one root bit
// per cycle. Each bisection step then evaluates the polynomial with a
// shared multiplier that takes one 17-bit digit of x per cycle.
// With a zero quadratic coefficient or a negative radicand the block skips
// the divider and the square root and finishes from its check state.
// The result appears on root_o, residual_o and status_o, held in registers,
// with done_o high for exactly one cycle; the receiver cannot stall, so it
// must take the beat then. In that cycle busy_o is low and a start is taken.
// Reset clears the controller to idle with no result pending.
module quadratic_bisection_root_top import qbr_pkg::*; #(
  parameter int FRAC_BITS     = FRAC_BITS_DEF,
  parameter int TOLERANCE_LSB = TOLERANCE_LSB_DEF,
  parameter int COEF_BITS     = COEF_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [COEF_BITS-1:0] coef_quad_i,
  input  logic signed [COEF_BITS-1:0] coef_lin_i,
  input  logic signed [COEF_BITS-1:0] coef_const_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic signed [ROOT_W-1:0]    root_o,
  output logic signed [RES_W-1:0]     residual_o,
  output logic [ST_W-1:0]             status_o
);

  cmd_t cmd;
  sts_t sts;

  qbr_controller #(
    .FRAC_BITS(FRAC_BITS),
    .COEF_BITS(COEF_BITS)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy_o),
    .done_o (done_o)
  );

  qbr_datapath #(
    .FRAC_BITS    (FRAC_BITS),
    .TOLERANCE_LSB(TOLERANCE_LSB),
    .COEF_BITS    (COEF_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .coef_quad_i (coef_quad_i),
    .coef_lin_i  (coef_lin_i),
    .coef_const_i(coef_const_i),
    .sts_o       (sts),
    .root_o      (root_o),
    .residual_o  (residual_o),
    .status_o    (status_o)
  );

endmodule

// ===== sv/qbr_datapath.sv =====
module qbr_datapath import qbr_pkg::*; #(
  parameter int FRAC_BITS     = FRAC_BITS_DEF,
  parameter int TOLERANCE_LSB = TOLERANCE_LSB_DEF,
  parameter int COEF_BITS     = COEF_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cmd_t                        cmd_i,
  input  logic signed [COEF_BITS-1:0] coef_quad_i,
  input  logic signed [COEF_BITS-1:0] coef_lin_i,
  input  logic signed [COEF_BITS-1:0] coef_const_i,
  output sts_t                        sts_o,
  output logic signed [ROOT_W-1:0]    root_o,
  output logic signed [RES_W-1:0]     residual_o,
  output logic [ST_W-1:0]             status_o
);

  localparam int CB   = COEF_BITS;
  localparam int F    = FRAC_BITS;
  localparam int NW   = 2 * CB + 2;
  localparam int DENW = 2 * CB;
  localparam int QW   = NW - 1 + 2 * F;
  localparam int RW   = (QW + 1) / 2;
  localparam int XW   = RW + 1;
  localparam int D    = DigitBits;
  localparam int ND   = (XW + D - 1) / D;
  localparam int XSW  = ND * D;
  localparam int PW   = ((CB + XW > CB + F + 1) ? CB + XW : CB + F + 1) + 1;
  localparam int FW   = PW + XW + 1;
  localparam int SRW  = RW + 3;
  localparam int SW   = (FW > RES_W + 1) ? FW : RES_W + 1;
  localparam logic [XW:0] TOL = (XW + 1)'(TOLERANCE_LSB);
  localparam logic signed [SW-1:0] RMAX = SW'({1'b0, {(RES_W - 1){1'b1}}});
  localparam logic signed [SW-1:0] RMIN = -RMAX - SW'(1);

  logic signed [CB-1:0]   a_q, b_q, c_q;
  logic signed [NW-1:0]   n_q, n_d;
  logic [DENW-1:0]        den_q, den_d;
  logic [DENW-1:0]        rem_q, rem_d;
  logic [QW-1:0]          quo_q, quo_d;
  logic [2*RW-1:0]        sq_q, sq_d;
  logic [RW-1:0]          rt_q, rt_d;
  logic [SRW-1:0]         srem_q, srem_d;
  logic signed [XW-1:0]   x0_q, x0_d, x1_q, x1_d, x2_q, x2_d, ex_q, ex_d;
  logic [XSW-1:0]         xs_q, xs_d;
  logic signed [PW-1:0]   mc_q, mc_d;
  logic signed [FW-1:0]   acc_q, acc_d;
  logic [1:0]             s1_q, s1_d, s2_q, s2_d;
  logic signed [ROOT_W-1:0] root_q, root_d;
  logic signed [RES_W-1:0]  res_q, res_d;
  logic [ST_W-1:0]        st_q, st_d;

  logic signed [2*CB-1:0] bb, ac;
  logic [CB-1:0]          a_mag;
  logic [DENW:0]          rem2;
  logic                   dge;
  logic [SRW-1:0]         srem2, trial;
  logic                   sge;
  logic signed [XW-1:0]   ex_sel;
  logic [D-1:0]           dig_u;
  logic signed [D:0]      dig;
  logic signed [PW+D:0]   prod;
  logic signed [XW:0]     xsum, d1, d2;
  logic [XW:0]            m1, m2;
  logic signed [SW-1:0]   fsh;
  logic                   f_neg, f_zero;

  always_comb begin
    bb    = b_q * b_q;
    ac    = a_q * c_q;
    a_mag = a_q[CB-1] ? CB'(-a_q) : CB'(a_q);
    n_d   = NW'(bb) - (NW'(ac) <<< 1);
    den_d = DENW'(a_mag) * DENW'(a_mag);
    rem2  = {rem_q, quo_q[QW-1]};
    dge   = rem2 >= {1'b0, den_q};
    srem2 = {srem_q[SRW-3:0], sq_q[2*RW-1 -: 2]};
    trial = SRW'({rt_q, 2'b01});
    sge   = srem2 >= trial;
    unique case (cmd_i.sel)
      SEL_X1:  ex_sel = x1_q;
      SEL_X2:  ex_sel = x2_q;
      default: ex_sel = x0_q;
    endcase
    dig_u  = xs_q[XSW-1 -: D];
    dig    = $signed({cmd_i.first ? dig_u[D-1] : 1'b0, dig_u});
    prod   = mc_q * dig;
    xsum   = (XW + 1)'(x1_q) + (XW + 1)'(x2_q);
    d1     = (XW + 1)'(x0_q) - (XW + 1)'(x1_q);
    d2     = (XW + 1)'(x0_q) - (XW + 1)'(x2_q);
    m1     = d1[XW] ? (XW + 1)'(-d1) : (XW + 1)'(d1);
    m2     = d2[XW] ? (XW + 1)'(-d2) : (XW + 1)'(d2);
    f_neg  = acc_q[FW-1];
    f_zero = acc_q == '0;
    fsh    = SW'(acc_q) >>> F;
  end

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    sq_d   = sq_q;
    rt_d   = rt_q;
    srem_d = srem_q;
    x0_d   = x0_q;
    x1_d   = x1_q;
    x2_d   = x2_q;
    ex_d   = ex_q;
    xs_d   = xs_q;
    mc_d   = mc_q;
    acc_d  = acc_q;
    s1_d   = s1_q;
    s2_d   = s2_q;
    root_d = root_q;
    res_d  = res_q;
    st_d   = st_q;
    unique case (cmd_i.op)
      OP_DIV_INIT: begin
        quo_d = {n_q[NW-2:0], {(2 * F){1'b0}}};
        rem_d = '0;
      end
      OP_DIV_STEP: begin
        rem_d = dge ? DENW'(rem2 - {1'b0, den_q}) : rem2[DENW-1:0];
        quo_d = {quo_q[QW-2:0], dge};
      end
      OP_SQRT_INIT: begin
        sq_d   = (2 * RW)'(quo_q);
        rt_d   = '0;
        srem_d = '0;
      end
      OP_SQRT_STEP: begin
        srem_d = sge ? srem2 - trial : srem2;
        rt_d   = {rt_q[RW-2:0], sge};
        sq_d   = sq_q << 2;
      end
      OP_BRACKET: begin
        x2_d = $signed({1'b0, rt_q});
        x1_d = -$signed({1'b0, rt_q});
      end
      OP_EV_START: begin
        ex_d  = ex_sel;
        xs_d  = XSW'(ex_sel);
        mc_d  = PW'(a_q);
        acc_d = '0;
      end
      OP_MUL_STEP: begin
        acc_d = (acc_q <<< D) + FW'(prod);
        xs_d  = xs_q << D;
      end
      OP_ADD_LIN: begin
        mc_d  = PW'(acc_q) + (PW'(b_q) <<< F);
        acc_d = '0;
        xs_d  = XSW'(ex_q);
      end
      OP_ADD_CONST: acc_d = acc_q + (FW'(c_q) <<< (2 * F));
      OP_SAVE_S1:   s1_d = {f_neg, f_zero};
      OP_SAVE_S2:   s2_d = {f_neg, f_zero};
      OP_MID:       x0_d = xsum[XW:1];
      OP_KEEP_LO: begin
        x2_d = x0_q;
        s2_d = {f_neg, f_zero};
      end
      OP_KEEP_HI: begin
        x1_d = x0_q;
        s1_d = {f_neg, f_zero};
      end
      OP_FINISH: begin
        st_d = cmd_i.status;
        if (cmd_i.status == ST_QUAD_ZERO || cmd_i.status == ST_NEG_RAD) begin
          root_d = '0;
          res_d  = '0;
        end else begin
          root_d = ROOT_W'(x0_q);
          if (fsh > RMAX) begin
            res_d = RES_W'(RMAX);
          end else if (fsh < RMIN) begin
            res_d = RES_W'(RMIN);
          end else begin
            res_d = RES_W'(fsh);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      a_q <= coef_quad_i;
      b_q <= coef_lin_i;
      c_q <= coef_const_i;
    end
    if (cmd_i.op == OP_CALC) begin
      n_q   <= n_d;
      den_q <= den_d;
    end
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    sq_q   <= sq_d;
    rt_q   <= rt_d;
    srem_q <= srem_d;
    x0_q   <= x0_d;
    x1_q   <= x1_d;
    x2_q   <= x2_d;
    ex_q   <= ex_d;
    xs_q   <= xs_d;
    mc_q   <= mc_d;
    acc_q  <= acc_d;
    s1_q   <= s1_d;
    s2_q   <= s2_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
      res_q  <= '0;
      st_q   <= ST_FOUND;
    end else begin
      root_q <= root_d;
      res_q  <= res_d;
      st_q   <= st_d;
    end
  end

  assign sts_o.a_zero  = a_q == '0;
  assign sts_o.n_neg   = n_q[NW-1];
  assign sts_o.stop    = (m1 <= TOL) && (m2 <= TOL);
  assign sts_o.f_neg   = f_neg;
  assign sts_o.f_zero  = f_zero;
  assign sts_o.s1_neg  = s1_q[1];
  assign sts_o.s1_zero = s1_q[0];
  assign sts_o.s2_neg  = s2_q[1];
  assign sts_o.s2_zero = s2_q[0];
  assign root_o        = root_q;
  assign residual_o    = res_q;
  assign status_o      = st_q;

endmodule

// ===== sv/qbr_controller.sv =====
`include "quadratic_bisection_root_top_defines.svh"

module qbr_controller import qbr_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int COEF_BITS = COEF_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o,
  output logic done_o
);

  localparam int NW = 2 * COEF_BITS + 2;
  localparam int QW = NW - 1 + 2 * FRAC_BITS;
  localparam int RW = (QW + 1) / 2;
  localparam int XW = RW + 1;
  localparam int ND = (XW + DigitBits - 1) / DigitBits;
  localparam int CW = $clog2(QW + 1);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_CALC      = 4'd1;
  localparam logic [3:0] S_CHECK     = 4'd2;
  localparam logic [3:0] S_DIV       = 4'd3;
  localparam logic [3:0] S_SQRT_INIT = 4'd4;
  localparam logic [3:0] S_SQRT      = 4'd5;
  localparam logic [3:0] S_BRACKET   = 4'd6;
  localparam logic [3:0] S_EV_START  = 4'd7;
  localparam logic [3:0] S_MUL1      = 4'd8;
  localparam logic [3:0] S_ADD1      = 4'd9;
  localparam logic [3:0] S_MUL2      = 4'd10;
  localparam logic [3:0] S_ADD2      = 4'd11;
  localparam logic [3:0] S_EV_RET    = 4'd12;
  localparam logic [3:0] S_MID       = 4'd13;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [1:0]    sel_q, sel_d;
  logic          done_q, done_d;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    sel_d        = sel_q;
    done_d       = 1'b0;
    cmd_o.op     = OP_NONE;
    cmd_o.sel    = sel_q;
    cmd_o.first  = 1'b0;
    cmd_o.status = ST_FOUND;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_CALC;
        end
      end
      S_CALC: begin
        cmd_o.op = OP_CALC;
        state_d  = S_CHECK;
      end
      S_CHECK: begin
        cnt_d = '0;
        priority if (sts_i.a_zero) begin
          cmd_o.op     = OP_FINISH;
          cmd_o.status = ST_QUAD_ZERO;
          done_d       = 1'b1;
          state_d      = S_IDLE;
        end else if (sts_i.n_neg) begin
          cmd_o.op     = OP_FINISH;
          cmd_o.status = ST_NEG_RAD;
          done_d       = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd_o.op = OP_DIV_INIT;
          state_d  = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        cnt_d    = cnt_q + CW'(1);
        if (cnt_q == CW'(QW - 1)) begin
          state_d = S_SQRT_INIT;
        end
      end
      S_SQRT_INIT: begin
        cmd_o.op = OP_SQRT_INIT;
        cnt_d    = '0;
        state_d  = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.op = OP_SQRT_STEP;
        cnt_d    = cnt_q + CW'(1);
        if (cnt_q == CW'(RW - 1)) begin
          state_d = S_BRACKET;
        end
      end
      S_BRACKET: begin
        cmd_o.op = OP_BRACKET;
        sel_d    = SEL_X1;
        state_d  = S_EV_START;
      end
      S_EV_START: begin
        cmd_o.op = OP_EV_START;
        cnt_d    = '0;
        state_d  = S_MUL1;
      end
      S_MUL1, S_MUL2: begin
        cmd_o.op    = OP_MUL_STEP;
        cmd_o.first = cnt_q == '0;
        cnt_d       = cnt_q + CW'(1);
        if (cnt_q == CW'(ND - 1)) begin
          state_d = (state_q == S_MUL1) ? S_ADD1 : S_ADD2;
        end
      end
      S_ADD1: begin
        cmd_o.op = OP_ADD_LIN;
        cnt_d    = '0;
        state_d  = S_MUL2;
      end
      S_ADD2: begin
        cmd_o.op = OP_ADD_CONST;
        state_d  = S_EV_RET;
      end
      S_EV_RET: begin
        unique case (sel_q)
          SEL_X1: begin
            cmd_o.op = OP_SAVE_S1;
            sel_d    = SEL_X2;
            state_d  = S_EV_START;
          end
          SEL_X2: begin
            cmd_o.op = OP_SAVE_S2;
            state_d  = S_MID;
          end
          default: begin
            priority if (sts_i.stop || sts_i.f_zero) begin
              cmd_o.op     = OP_FINISH;
              cmd_o.status = ST_FOUND;
              done_d       = 1'b1;
              state_d      = S_IDLE;
            end else if (!sts_i.s1_zero && (sts_i.f_neg != sts_i.s1_neg)) begin
              cmd_o.op = OP_KEEP_LO;
              state_d  = S_MID;
            end else if (!sts_i.s2_zero && (sts_i.f_neg != sts_i.s2_neg)) begin
              cmd_o.op = OP_KEEP_HI;
              state_d  = S_MID;
            end else begin
              cmd_o.op     = OP_FINISH;
              cmd_o.status = ST_NO_CHANGE;
              done_d       = 1'b1;
              state_d      = S_IDLE;
            end
          end
        endcase
      end
      S_MID: begin
        cmd_o.op = OP_MID;
        sel_d    = SEL_X0;
        state_d  = S_EV_START;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      sel_q   <= SEL_X1;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sel_q   <= sel_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = state_q != S_IDLE;
  assign done_o = done_q;

  `QBR_ASSERT(a_done_idle, done_o |-> state_q == S_IDLE)
  `QBR_ASSERT(a_done_pulse, done_o |=> !done_o)
  `QBR_ASSERT(a_start_busy, (start_i && !busy_o) |=> busy_o)
  `QBR_ASSERT(a_div_cnt, (state_q == S_DIV) |-> (cnt_q < CW'(QW)))
  `QBR_ASSERT_RST(a_rst_quiet, !rst_ni |=> !done_o || $past(done_d))

endmodule
